[hdl/vic_pkg.sv]
package vic_pkg;

  localparam int DATA_W = 32;
  localparam int SRC_W  = 5;
  localparam int OFS_W  = 9;
  localparam int ACT_W  = 2;
  localparam int TBL_DEPTH = 32;
  localparam int TBL_IDX_W = 5;
  localparam int CLS_W  = 2;

  // bit of a mode entry that marks an edge-triggered source
  localparam int EDGE_BIT = 5;

  typedef logic [DATA_W-1:0]    word_t;
  typedef logic [TBL_IDX_W-1:0] tbl_idx_t;

  // transfer kinds
  localparam logic [ACT_W-1:0] ACT_RAISE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd2;

  // register offsets above the two tables
  localparam logic [OFS_W-1:0] OFS_IVR   = 9'h100;
  localparam logic [OFS_W-1:0] OFS_FVR   = 9'h104;
  localparam logic [OFS_W-1:0] OFS_ISR   = 9'h108;
  localparam logic [OFS_W-1:0] OFS_IPR   = 9'h10C;
  localparam logic [OFS_W-1:0] OFS_IMR   = 9'h110;
  localparam logic [OFS_W-1:0] OFS_CISR  = 9'h114;
  localparam logic [OFS_W-1:0] OFS_IECR  = 9'h120;
  localparam logic [OFS_W-1:0] OFS_IDCR  = 9'h124;
  localparam logic [OFS_W-1:0] OFS_ICCR  = 9'h128;
  localparam logic [OFS_W-1:0] OFS_ISCR  = 9'h12C;
  localparam logic [OFS_W-1:0] OFS_EOICR = 9'h130;
  localparam logic [OFS_W-1:0] OFS_SPU   = 9'h134;
  localparam logic [OFS_W-1:0] OFS_DCR   = 9'h138;
  localparam logic [OFS_W-1:0] OFS_FFER  = 9'h140;
  localparam logic [OFS_W-1:0] OFS_FFDR  = 9'h144;
  localparam logic [OFS_W-1:0] OFS_FFSR  = 9'h148;

endpackage

[hdl/vic_in_if.sv]
interface vic_in_if;
  import vic_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [SRC_W-1:0]   source_line;
  logic [OFS_W-1:0]   reg_offset;
  logic [DATA_W-1:0]  write_data;

  modport source (output valid, action, source_line, reg_offset, write_data, input ready);
  modport sink   (input valid, action, source_line, reg_offset, write_data, output ready);
endinterface

[hdl/vic_out_if.sv]
interface vic_out_if;
  import vic_pkg::*;

  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  read_data;
  logic               fiq_event;
  logic               irq_event;
  logic               bad_address;

  modport source (output valid, read_data, fiq_event, irq_event, bad_address, input ready);
  modport sink   (input valid, read_data, fiq_event, irq_event, bad_address, output ready);
endinterface

[hdl/vectored_interrupt_controller.sv]
// Channel  Dir  Payload                                        Transfer
// in_ch    in   action, source_line, reg_offset, write_data    valid & ready
// out_ch   out  read_data, fiq_event, irq_event, bad_address   valid & ready
//
// Two-stage flow: the mode and vector tables are read at the input transfer,
// the result and all register updates then pass from stage 1 into the output
// register. One item per cycle is sustained while the output does not stall.
// Synchronous reset clears the valid flags and controller state at once;
// unwritten table entries read as zero. A stalled output holds both stages.
module vectored_interrupt_controller #(
  parameter int NUM_SOURCES = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  vic_in_if.sink    in_ch,
  vic_out_if.source out_ch
);
  import vic_pkg::*;

  localparam int CMP_W = SRC_W + 1;

  // ---------------- stage 0: accept and issue table accesses
  logic     in_fire;
  logic     s1_fire;
  logic     in_tbl;
  logic     in_vec;
  tbl_idx_t in_idx;
  logic     mode_we;
  logic     vec_we;
  tbl_idx_t vec_raddr;
  word_t    mode_rd;
  word_t    vec_rd;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_tbl  = !in_ch.reg_offset[8];
  assign in_vec  = in_ch.reg_offset[7];
  assign in_idx  = in_ch.reg_offset[6:2];

  assign mode_we   = in_fire && (in_ch.action == ACT_WRITE) && in_tbl && !in_vec;
  assign vec_we    = in_fire && (in_ch.action == ACT_WRITE) && in_tbl && in_vec;
  assign vec_raddr = (in_ch.action == ACT_RAISE) ? in_ch.source_line : in_idx;

  vic_tbl_mem u_mode_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mode_we),
    .wr_addr (in_idx),
    .wr_data (in_ch.write_data),
    .rd_en   (in_fire),
    .rd_addr (in_idx),
    .rd_data (mode_rd)
  );

  vic_tbl_mem u_vec_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (vec_we),
    .wr_addr (in_idx),
    .wr_data (in_ch.write_data),
    .rd_en   (in_fire),
    .rd_addr (vec_raddr),
    .rd_data (vec_rd)
  );

  // copy of vector entry 0 for fast raises
  word_t vt0_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vt0_r <= '0;
    end else if (vec_we && (in_idx == '0)) begin
      vt0_r <= in_ch.write_data;
    end
  end

  // ---------------- stage 1 registers
  logic             s1_v_r;
  logic [ACT_W-1:0] s1_act_r;
  logic [SRC_W-1:0] s1_line_r;
  logic [OFS_W-1:0] s1_ofs_r;
  word_t            s1_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_fire) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_act_r  <= in_ch.action;
      s1_line_r <= in_ch.source_line;
      s1_ofs_r  <= in_ch.reg_offset;
      s1_data_r <= in_ch.write_data;
    end
  end

  // ---------------- controller state
  word_t            pend_r,  pend_nxt;
  word_t            en_r,    en_nxt;
  word_t            ff_r,    ff_nxt;
  word_t            edge_r,  edge_nxt;
  logic [SRC_W-1:0] cs_r,    cs_nxt;
  word_t            irqv_r,  irqv_nxt;
  word_t            fiqv_r,  fiqv_nxt;
  logic [CLS_W-1:0] cls_r,   cls_nxt;
  word_t            spu_r,   spu_nxt;
  word_t            dcr_r,   dcr_nxt;

  word_t            res_data;
  logic             res_fiq;
  logic             res_irq;
  logic             res_bad;

  logic             out_v_r;
  word_t            out_data_r;
  logic             out_fiq_r;
  logic             out_irq_r;
  logic             out_bad_r;

  assign s1_fire     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_fire;

  // ---------------- stage 1 decode and update
  word_t    line_bit;
  word_t    cs_bit;
  logic     raise_hit;
  logic     raise_fast;
  logic     s1_tbl;
  logic     s1_vec;
  tbl_idx_t s1_idx;

  assign line_bit   = word_t'(1) << s1_line_r;
  assign cs_bit     = word_t'(1) << cs_r;
  assign raise_hit  = (CMP_W'(s1_line_r) < CMP_W'(NUM_SOURCES)) && (|(en_r & line_bit));
  assign raise_fast = (s1_line_r == '0) || (|(ff_r & line_bit));
  assign s1_tbl     = !s1_ofs_r[8];
  assign s1_vec     = s1_ofs_r[7];
  assign s1_idx     = s1_ofs_r[6:2];

  always_comb begin
    pend_nxt = pend_r;
    en_nxt   = en_r;
    ff_nxt   = ff_r;
    edge_nxt = edge_r;
    cs_nxt   = cs_r;
    irqv_nxt = irqv_r;
    fiqv_nxt = fiqv_r;
    cls_nxt  = cls_r;
    spu_nxt  = spu_r;
    dcr_nxt  = dcr_r;
    res_data = '0;
    res_fiq  = 1'b0;
    res_irq  = 1'b0;
    res_bad  = 1'b0;

    case (s1_act_r)
      ACT_RAISE: begin
        if (raise_hit) begin
          pend_nxt = pend_r | line_bit;
          cs_nxt   = s1_line_r;
          if (raise_fast) begin
            fiqv_nxt   = vt0_r;
            cls_nxt[0] = 1'b1;
            res_fiq    = 1'b1;
          end else begin
            irqv_nxt   = vec_rd;
            cls_nxt[1] = 1'b1;
            res_irq    = 1'b1;
          end
        end
      end
      ACT_READ: begin
        if (s1_tbl) begin
          res_data = s1_vec ? vec_rd : mode_rd;
        end else begin
          unique case (s1_ofs_r)
            OFS_IVR: begin
              if (pend_r[DATA_W-1:1] == '0) begin
                res_data = spu_r;
              end else begin
                pend_nxt = pend_r | cs_bit;
                if (!(|(ff_r & cs_bit))) begin
                  cls_nxt[1] = 1'b0;
                  if (|(edge_r & cs_bit)) begin
                    pend_nxt = pend_r & ~cs_bit;
                  end
                end
                res_data = irqv_r;
              end
            end
            OFS_FVR: begin
              if (!pend_r[0]) begin
                res_data = spu_r;
              end else if (cs_r != '0) begin
                res_data = '0;
              end else begin
                if (edge_r[0]) begin
                  pend_nxt[0] = 1'b0;
                end
                res_data = fiqv_r;
              end
            end
            OFS_ISR: begin
              res_data = DATA_W'(cs_r);
              cs_nxt   = '0;
              pend_nxt = '0;
              irqv_nxt = '0;
            end
            OFS_IPR: begin
              res_data = pend_r;
              pend_nxt = '0;
            end
            OFS_IMR:  res_data = en_r;
            OFS_CISR: res_data = DATA_W'(cls_r);
            OFS_SPU:  res_data = spu_r;
            OFS_DCR:  res_data = dcr_r;
            OFS_FFSR: res_data = ff_r;
            default:  res_bad  = 1'b1;
          endcase
        end
      end
      ACT_WRITE: begin
        if (s1_tbl) begin
          // mirror the edge flag of mode writes
          if (!s1_vec) begin
            edge_nxt[s1_idx] = s1_data_r[EDGE_BIT];
          end
        end else begin
          unique case (s1_ofs_r)
            OFS_IECR:  en_nxt   = en_r | s1_data_r;
            OFS_IDCR:  en_nxt   = en_r & ~s1_data_r;
            OFS_ICCR:  pend_nxt = pend_r & ~(s1_data_r & edge_r);
            OFS_ISCR:  pend_nxt = pend_r | (s1_data_r & edge_r);
            OFS_EOICR: ;
            OFS_SPU:   spu_nxt  = s1_data_r;
            OFS_DCR:   dcr_nxt  = s1_data_r;
            OFS_FFER:  ff_nxt   = ff_r | s1_data_r;
            OFS_FFDR:  ff_nxt   = ff_r & ~s1_data_r;
            default:   res_bad  = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

  // commit state when the item moves into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      en_r   <= '0;
      ff_r   <= '0;
      edge_r <= '0;
      cs_r   <= '0;
      irqv_r <= '0;
      fiqv_r <= '0;
      cls_r  <= '0;
      spu_r  <= '0;
      dcr_r  <= '0;
    end else if (s1_fire) begin
      pend_r <= pend_nxt;
      en_r   <= en_nxt;
      ff_r   <= ff_nxt;
      edge_r <= edge_nxt;
      cs_r   <= cs_nxt;
      irqv_r <= irqv_nxt;
      fiqv_r <= fiqv_nxt;
      cls_r  <= cls_nxt;
      spu_r  <= spu_nxt;
      dcr_r  <= dcr_nxt;
    end
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= res_data;
      out_fiq_r  <= res_fiq;
      out_irq_r  <= res_irq;
      out_bad_r  <= res_bad;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.read_data   = out_data_r;
  assign out_ch.fiq_event   = out_fiq_r;
  assign out_ch.irq_event   = out_irq_r;
  assign out_ch.bad_address = out_bad_r;

`ifndef SYNTH
  a_raise_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_act_r == ACT_RAISE) && raise_hit) |=> pend_r[$past(s1_line_r)])
    else $error("accepted raise did not set its pending bit");

  a_isr_clears_source: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_act_r == ACT_READ) && (s1_ofs_r == OFS_ISR)) |=> (cs_r == '0))
    else $error("status read did not clear the current source");

  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_fiq_r && out_irq_r) && !(out_bad_r && (out_fiq_r || out_irq_r)))
    else $error("conflicting result flags");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_fire) |=> s1_v_r && $stable(s1_ofs_r) && $stable(s1_act_r))
    else $error("stalled item lost from second stage");
`endif

endmodule

[hdl/vic_tbl_mem.sv]
module vic_tbl_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  vic_pkg::tbl_idx_t wr_addr,
  input  vic_pkg::word_t    wr_data,
  input  logic              rd_en,
  input  vic_pkg::tbl_idx_t rd_addr,
  output vic_pkg::word_t    rd_data
);
  import vic_pkg::*;

  word_t                mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] vld_r;
  word_t                rd_r;
  logic                 rd_vld_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // mark written entries; unwritten ones read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // registered read port, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_r : '0;

endmodule
